FILE: sv/kuf_pkg.sv
// Shared widths and constants for the union-find spanning tree engine.
// No dependencies; compile first.
package kuf_pkg;

    localparam int NODES_DEF = 16;
    localparam int WEIGHT_W  = 16;
    localparam int NODE_IN_W = 4;
    localparam int COST_W    = 20;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

endpackage

FILE: sv/kuf_if.sv
// Valid/ready channel interfaces for edge items and result items.
// Depends on kuf_pkg.
interface kuf_edge_if;
    import kuf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [WEIGHT_W-1:0]  edge_weight;
    logic [NODE_IN_W-1:0] node_u;
    logic [NODE_IN_W-1:0] node_v;
    logic                 last_edge;

    modport source (output valid, edge_weight, node_u, node_v, last_edge, input ready);
    modport sink   (input valid, edge_weight, node_u, node_v, last_edge, output ready);
endinterface

interface kuf_result_if;
    import kuf_pkg::*;

    logic              valid;
    logic              ready;
    logic              merged;
    logic [COST_W-1:0] total_cost;
    logic              graph_done;

    modport source (output valid, merged, total_cost, graph_done, input ready);
    modport sink   (input valid, merged, total_cost, graph_done, output ready);
endinterface

FILE: sv/kuf_forest_mem.sv
// Parent and set-size memories of the disjoint-set forest.
// One write and one registered read port each; depends on kuf_pkg for the default size.
module kuf_forest_mem #(
    parameter int NODES  = kuf_pkg::NODES_DEF,
    parameter int NODE_W = $clog2(NODES),
    parameter int SIZE_W = $clog2(NODES + 1)
) (
    input  logic              clk,
    input  logic              p_we,
    input  logic [NODE_W-1:0] p_waddr,
    input  logic [NODE_W-1:0] p_wdata,
    input  logic [NODE_W-1:0] p_raddr,
    output logic [NODE_W-1:0] p_rdata,
    input  logic              s_we,
    input  logic [NODE_W-1:0] s_waddr,
    input  logic [SIZE_W-1:0] s_wdata,
    input  logic [NODE_W-1:0] s_raddr,
    output logic [SIZE_W-1:0] s_rdata
);

    logic [NODE_W-1:0] parent_mem [NODES];
    logic [SIZE_W-1:0] size_mem   [NODES];

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            parent_mem[p_waddr] <= p_wdata;
        end
        p_rdata <= parent_mem[p_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            size_mem[s_waddr] <= s_wdata;
        end
        s_rdata <= size_mem[s_raddr];
    end

endmodule

FILE: sv/kuf_cost_acc.sv
// Running tree cost with saturating add.
// Depends on kuf_pkg.
module kuf_cost_acc (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  logic                          add_en,
    input  logic [kuf_pkg::WEIGHT_W-1:0]  weight,
    output logic [kuf_pkg::COST_W-1:0]    cost
);
    import kuf_pkg::*;

    logic [COST_W-1:0] cost_reg;
    logic [COST_W-1:0] cost_next;
    logic [COST_W:0]   sum;

    assign sum = {1'b0, cost_reg} + (COST_W + 1)'(weight);

    always_comb
    begin
        cost_next = cost_reg;
        if (clear)
        begin
            cost_next = '0;
        end
        else if (add_en)
        begin
            cost_next = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cost_reg <= '0;
        end
        else
        begin
            cost_reg <= cost_next;
        end
    end

    assign cost = cost_reg;

endmodule

FILE: sv/kruskal_union_find_engine.sv
// Kruskal union-find engine: one edge item in, one result item out.
// An accepted edge walks each endpoint to its root and compresses the path; differing
// roots are then merged by set size. An ignored edge skips the finds and goes to the result.
// One edge at a time; ready returns the cycle after the result is taken.
// After reset and after each last edge, a clearing pass over all nodes rebuilds the forest.
module kruskal_union_find_engine #(
    parameter int NODES = kuf_pkg::NODES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    kuf_edge_if.sink      edge_in,
    kuf_result_if.source  result_out
);
    import kuf_pkg::*;

    localparam int NODE_W = $clog2(NODES);
    localparam int SIZE_W = $clog2(NODES + 1);

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_FIND_U = 9'b000000100,
        S_COMP_U = 9'b000001000,
        S_FIND_V = 9'b000010000,
        S_COMP_V = 9'b000100000,
        S_SIZE_A = 9'b001000000,
        S_SIZE_B = 9'b010000000,
        S_OUT    = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    logic [NODE_W-1:0]   idx_reg, idx_next;

    logic [WEIGHT_W-1:0] weight_reg, weight_next;
    logic [NODE_W-1:0]   u_reg, u_next;
    logic [NODE_W-1:0]   v_reg, v_next;
    logic                last_reg, last_next;
    logic [NODE_W-1:0]   walk_reg, walk_next;
    logic [NODE_W-1:0]   root_a_reg, root_a_next;
    logic [NODE_W-1:0]   root_b_reg, root_b_next;
    logic [SIZE_W-1:0]   size_a_reg, size_a_next;
    logic                merged_reg, merged_next;

    logic                p_we, s_we;
    logic [NODE_W-1:0]   p_waddr, p_wdata, p_raddr, p_rdata;
    logic [NODE_W-1:0]   s_waddr, s_raddr;
    logic [SIZE_W-1:0]   s_wdata, s_rdata;

    logic                cost_clear, cost_add;
    logic [COST_W-1:0]   cost;

    logic                edge_ok;
    logic                swap;
    logic [NODE_W-1:0]   big_root, small_root;

    kuf_forest_mem #(
        .NODES  (NODES),
        .NODE_W (NODE_W),
        .SIZE_W (SIZE_W)
    ) u_forest (
        .clk     (clk),
        .p_we    (p_we),
        .p_waddr (p_waddr),
        .p_wdata (p_wdata),
        .p_raddr (p_raddr),
        .p_rdata (p_rdata),
        .s_we    (s_we),
        .s_waddr (s_waddr),
        .s_wdata (s_wdata),
        .s_raddr (s_raddr),
        .s_rdata (s_rdata)
    );

    kuf_cost_acc u_cost (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (cost_clear),
        .add_en (cost_add),
        .weight (weight_reg),
        .cost   (cost)
    );

    assign edge_ok = (edge_in.edge_weight != '0)
                  && (32'(edge_in.node_u) < 32'(NODES))
                  && (32'(edge_in.node_v) < 32'(NODES));

    assign swap       = size_a_reg < s_rdata;
    assign big_root   = swap ? root_b_reg : root_a_reg;
    assign small_root = swap ? root_a_reg : root_b_reg;

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        weight_next = weight_reg;
        u_next      = u_reg;
        v_next      = v_reg;
        last_next   = last_reg;
        walk_next   = walk_reg;
        root_a_next = root_a_reg;
        root_b_next = root_b_reg;
        size_a_next = size_a_reg;
        merged_next = merged_reg;
        p_we        = 1'b0;
        p_waddr     = walk_reg;
        p_wdata     = root_a_reg;
        p_raddr     = walk_reg;
        s_we        = 1'b0;
        s_waddr     = idx_reg;
        s_wdata     = SIZE_W'(1);
        s_raddr     = root_a_reg;
        cost_clear  = 1'b0;
        cost_add    = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                p_we    = 1'b1;
                p_waddr = idx_reg;
                p_wdata = idx_reg;
                s_we    = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == NODE_W'(NODES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (edge_in.valid)
                begin
                    weight_next = edge_in.edge_weight;
                    u_next      = NODE_W'(edge_in.node_u);
                    v_next      = NODE_W'(edge_in.node_v);
                    last_next   = edge_in.last_edge;
                    walk_next   = NODE_W'(edge_in.node_u);
                    p_raddr     = NODE_W'(edge_in.node_u);
                    merged_next = 1'b0;
                    state_next  = edge_ok ? S_FIND_U : S_OUT;
                end
            end
            S_FIND_U:
            begin
                if (p_rdata == walk_reg)
                begin
                    root_a_next = walk_reg;
                    walk_next   = u_reg;
                    p_raddr     = u_reg;
                    state_next  = S_COMP_U;
                end
                else
                begin
                    walk_next = p_rdata;
                    p_raddr   = p_rdata;
                end
            end
            S_COMP_U:
            begin
                if (walk_reg == root_a_reg)
                begin
                    walk_next  = v_reg;
                    p_raddr    = v_reg;
                    state_next = S_FIND_V;
                end
                else
                begin
                    p_we      = 1'b1;
                    p_wdata   = root_a_reg;
                    walk_next = p_rdata;
                    p_raddr   = p_rdata;
                end
            end
            S_FIND_V:
            begin
                if (p_rdata == walk_reg)
                begin
                    root_b_next = walk_reg;
                    walk_next   = v_reg;
                    p_raddr     = v_reg;
                    state_next  = S_COMP_V;
                end
                else
                begin
                    walk_next = p_rdata;
                    p_raddr   = p_rdata;
                end
            end
            S_COMP_V:
            begin
                if (walk_reg == root_b_reg)
                begin
                    s_raddr    = root_a_reg;
                    state_next = (root_a_reg == root_b_reg) ? S_OUT : S_SIZE_A;
                end
                else
                begin
                    p_we      = 1'b1;
                    p_wdata   = root_b_reg;
                    walk_next = p_rdata;
                    p_raddr   = p_rdata;
                end
            end
            S_SIZE_A:
            begin
                size_a_next = s_rdata;
                s_raddr     = root_b_reg;
                state_next  = S_SIZE_B;
            end
            S_SIZE_B:
            begin
                // equal sizes keep the root of node_u on top
                p_we        = 1'b1;
                p_waddr     = small_root;
                p_wdata     = big_root;
                s_we        = 1'b1;
                s_waddr     = big_root;
                s_wdata     = size_a_reg + s_rdata;
                cost_add    = 1'b1;
                merged_next = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (result_out.ready)
                begin
                    if (last_reg)
                    begin
                        cost_clear = 1'b1;
                        idx_next   = '0;
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_CLEAR;
                idx_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        weight_reg <= weight_next;
        u_reg      <= u_next;
        v_reg      <= v_next;
        last_reg   <= last_next;
        walk_reg   <= walk_next;
        root_a_reg <= root_a_next;
        root_b_reg <= root_b_next;
        size_a_reg <= size_a_next;
        merged_reg <= merged_next;
    end

    assign edge_in.ready         = (state_reg == S_IDLE);
    assign result_out.valid      = (state_reg == S_OUT);
    assign result_out.merged     = merged_reg;
    assign result_out.total_cost = cost;
    assign result_out.graph_done = last_reg;

    a_one_side_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid |-> !edge_in.ready)
        else $error("input ready while a result is pending");

    a_merge_has_cost: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid && result_out.merged |-> result_out.total_cost != '0)
        else $error("merged edge left the cost at zero");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid && result_out.ready && result_out.graph_done
        |=> !edge_in.ready && result_out.total_cost == '0)
        else $error("state not reinitialized after last edge");

endmodule

FILE: tb/tb_kruskal_union_find_engine.sv
`timescale 1ns / 1ps
// Self-checking testbench for kruskal_union_find_engine: edge items in, result items out.
// Predicts the disjoint-set forest and running cost, compares each result in order.
// Depends on kuf_pkg, kuf_if and the engine RTL.
module tb_kruskal_union_find_engine;
    import kuf_pkg::*;

    localparam int NODES       = NODES_DEF;
    localparam int SIZE_W      = 5;
    localparam int DRAIN_LIMIT = 200000;
    localparam int TAIL_CYCLES = 100;

    typedef struct packed {
        logic [WEIGHT_W-1:0]  edge_weight;
        logic [NODE_IN_W-1:0] node_u;
        logic [NODE_IN_W-1:0] node_v;
        logic                 last_edge;
    } edge_item_t;

    typedef struct packed {
        logic              merged;
        logic [COST_W-1:0] total_cost;
        logic              graph_done;
    } tree_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    kuf_edge_if   edge_ch ();
    kuf_result_if result_ch ();

    kruskal_union_find_engine #(.NODES(NODES)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .edge_in    (edge_ch),
        .result_out (result_ch)
    );

    logic [NODE_IN_W-1:0] parent_tbl [NODES];
    logic [SIZE_W-1:0]    size_tbl [NODES];
    logic [COST_W-1:0]    cost_acc;

    tree_result_t expected_results [$];

    int send_idle_pct = 25;
    int recv_stall_pct = 71;
    int edges_sent = 0;
    int graphs_closed = 0;
    int merges_seen = 0;
    int mismatches = 0;
    int failures = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void forest_clear();
        for (int i = 0; i < NODES; i++)
        begin
            parent_tbl[i] = NODE_IN_W'(i);
            size_tbl[i]   = SIZE_W'(1);
        end
        cost_acc = '0;
    endfunction

    function automatic logic [NODE_IN_W-1:0] find_root(input logic [NODE_IN_W-1:0] node);
        logic [NODE_IN_W-1:0] r;
        logic [NODE_IN_W-1:0] cur;
        logic [NODE_IN_W-1:0] nxt;
        int steps;
        r = node;
        steps = 0;
        while (steps < NODES && parent_tbl[r] != r)
        begin
            r = parent_tbl[r];
            steps++;
        end
        cur = node;
        steps = 0;
        while (steps < NODES && cur != r)
        begin
            nxt = parent_tbl[cur];
            parent_tbl[cur] = r;
            cur = nxt;
            steps++;
        end
        return r;
    endfunction

    function automatic tree_result_t apply_edge(input edge_item_t e);
        tree_result_t res;
        logic [NODE_IN_W-1:0] ra;
        logic [NODE_IN_W-1:0] rb;
        logic [NODE_IN_W-1:0] t;
        logic [COST_W:0] sum;
        res.merged = 1'b0;
        if (e.edge_weight != '0 && int'(e.node_u) < NODES && int'(e.node_v) < NODES)
        begin
            ra = find_root(e.node_u);
            rb = find_root(e.node_v);
            if (ra != rb)
            begin
                if (size_tbl[ra] < size_tbl[rb])
                begin
                    t  = ra;
                    ra = rb;
                    rb = t;
                end
                parent_tbl[rb] = ra;
                size_tbl[ra]   = size_tbl[ra] + size_tbl[rb];
                sum = {1'b0, cost_acc} + (COST_W + 1)'(e.edge_weight);
                cost_acc = (sum > {1'b0, COST_MAX}) ? COST_MAX : sum[COST_W-1:0];
                res.merged = 1'b1;
            end
        end
        res.total_cost = cost_acc;
        res.graph_done = e.last_edge;
        if (e.last_edge)
            forest_clear();
        return res;
    endfunction

    task automatic send_edge(input logic [WEIGHT_W-1:0] w, input logic [NODE_IN_W-1:0] u,
                             input logic [NODE_IN_W-1:0] v, input logic last);
        edge_item_t e;
        tree_result_t exp_item;
        e = '{edge_weight: w, node_u: u, node_v: v, last_edge: last};
        while ($urandom_range(99) < send_idle_pct)
        begin
            edge_ch.valid <= 1'b0;
            @(posedge clk);
        end
        edge_ch.valid       <= 1'b1;
        edge_ch.edge_weight <= e.edge_weight;
        edge_ch.node_u      <= e.node_u;
        edge_ch.node_v      <= e.node_v;
        edge_ch.last_edge   <= e.last_edge;
        @(posedge clk);
        while (!edge_ch.ready)
            @(posedge clk);
        exp_item = apply_edge(e);
        expected_results = {expected_results, exp_item};
        edges_sent++;
    endtask

    always @(posedge clk)
    begin
        tree_result_t exp_r;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (result_ch.merged === 1'b1)
                merges_seen++;
            if (result_ch.graph_done === 1'b1)
                graphs_closed++;
            if (expected_results.size() == 0)
            begin
                failures++;
                if (mismatches < 10)
                    $display("%0t: result item with nothing expected", $realtime);
                mismatches++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (result_ch.merged !== exp_r.merged ||
                    result_ch.total_cost !== exp_r.total_cost ||
                    result_ch.graph_done !== exp_r.graph_done)
                begin
                    failures++;
                    if (mismatches < 10)
                        $display({"%0t: mismatch exp merged=%0b cost=%0d done=%0b, ",
                                  "got merged=%0b cost=%0d done=%0b"},
                                 $realtime, exp_r.merged, exp_r.total_cost, exp_r.graph_done,
                                 result_ch.merged, result_ch.total_cost, result_ch.graph_done);
                    mismatches++;
                end
            end
        end
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // zero weight, self loop, equal sizes, smaller u set, same set, last on a no-edge
    task automatic test_edge_cases();
        send_edge(16'd0, 4'd0, 4'd15, 1'b0);
        send_edge(16'd7, 4'd4, 4'd4, 1'b0);
        send_edge(16'd1, 4'd0, 4'd1, 1'b0);
        send_edge(16'd3, 4'd5, 4'd1, 1'b0);
        send_edge(16'd2, 4'd1, 4'd5, 1'b0);
        send_edge(16'd0, 4'd2, 4'd3, 1'b1);
    endtask

    // binomial merges so later finds walk and compress multi-hop chains
    task automatic test_full_tree();
        for (int k = 0; k < 8; k++)
            send_edge(16'hFFFF, NODE_IN_W'(2 * k), NODE_IN_W'(2 * k + 1), 1'b0);
        for (int k = 0; k < 4; k++)
            send_edge(16'hFFFF, NODE_IN_W'(4 * k + 1), NODE_IN_W'(4 * k + 3), 1'b0);
        send_edge(16'hFFFF, 4'd3, 4'd7, 1'b0);
        send_edge(16'hFFFF, 4'd11, 4'd15, 1'b0);
        send_edge(16'hFFFF, 4'd6, 4'd1, 1'b0);
        send_edge(16'hFFFF, 4'd15, 4'd7, 1'b1);
    endtask

    task automatic test_random_graphs(input int idle_pct, input int stall_pct, input int n_items);
        int sent;
        int len;
        int kind;
        int span;
        int dec_max;
        logic [WEIGHT_W-1:0] w;
        logic [NODE_IN_W-1:0] u;
        logic [NODE_IN_W-1:0] v;
        logic last;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items)
        begin
            len  = $urandom_range(40, 1);
            kind = $urandom_range(9);
            span = (kind < 3) ? $urandom_range(15, 2) : 15;
            w = ($urandom_range(3) == 0) ? 16'hFFFF : WEIGHT_W'($urandom);
            if (w == '0)
                w = 16'd1;
            for (int k = 0; k < len; k++)
            begin
                last = (k == len - 1);
                if (kind == 9)
                begin
                    // noise: unsorted, frequent no-edges, early closes
                    w = ($urandom_range(2) == 0) ? '0 : WEIGHT_W'($urandom);
                    last = last || ($urandom_range(7) == 0);
                end
                else if (k > 0 && w > 16'd1)
                begin
                    dec_max = (int'(w) - 1 < 4000) ? int'(w) - 1 : 4000;
                    w = w - WEIGHT_W'($urandom_range(dec_max, 0));
                end
                u = NODE_IN_W'($urandom_range(span, 0));
                v = NODE_IN_W'($urandom_range(span, 0));
                send_edge(w, u, v, last);
            end
            sent += len;
        end
    endtask

    initial
    begin
        int waited;
        edge_ch.valid       = 1'b0;
        edge_ch.edge_weight = '0;
        edge_ch.node_u      = '0;
        edge_ch.node_v      = '0;
        edge_ch.last_edge   = 1'b0;
        result_ch.ready     = 1'b0;
        forest_clear();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_edge_cases();
        test_full_tree();
        test_random_graphs(25, 71, 250);
        test_random_graphs(71, 25, 250);
        test_random_graphs(0, 0, 250);
        edge_ch.valid <= 1'b0;

        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            failures++;
            $display("%0d result items never arrived", expected_results.size());
        end

        $display("Covered %0d edge items over %0d closed graphs, %0d merges,",
                 edges_sent, graphs_closed, merges_seen);
        $display("under three idle profiles. Mismatches: %0d", mismatches);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("Timeout waiting on the engine");
        $display("Some tests failed");
        $finish;
    end

endmodule
